// ----- sv/dssg_pkg.sv -----
`default_nettype none
package dssg_pkg;

	localparam int MAX_LINE_WIDTH_DEF = 64;

	localparam int COORD_W = 16;
	localparam int SPAN_W  = 17;
	localparam int LW_W    = 7;
	localparam int XY_W    = 6;
	localparam int E_W     = 12;

	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;
	localparam int REG_IDX_W = APB_AW - 2;

	localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = '0;
	localparam logic [LW_W-1:0]      LINE_WIDTH_RST = 7'd1;

	typedef enum logic {
		OP_ROW  = 1'b0,
		OP_STEP = 1'b1
	} adder_op_t;

endpackage
`default_nettype wire

// ----- sv/dssg_adder.sv -----
`default_nettype none
module dssg_adder (
	input  dssg_pkg::adder_op_t                 op,
	input  logic signed [dssg_pkg::E_W-1:0]     e,
	input  logic        [dssg_pkg::XY_W-1:0]    x,
	input  logic        [dssg_pkg::XY_W-1:0]    y,
	output logic signed [dssg_pkg::E_W-1:0]     sum,
	output logic signed [dssg_pkg::E_W-1:0]     ex_step
);
	import dssg_pkg::*;

	logic signed [E_W-1:0] y8;
	logic signed [E_W-1:0] x8;
	logic signed [E_W-1:0] operand;

	// row entry adds 8y-4, an x step adds -(8(x+1)+4)
	assign y8      = {{(E_W-XY_W-3){1'b0}}, y, 3'b000};
	assign x8      = {{(E_W-XY_W-3){1'b0}}, x, 3'b000};
	assign ex_step = -(x8 + E_W'(12));
	assign operand = (op == OP_ROW) ? (y8 - E_W'(4)) : ex_step;
	assign sum     = e + operand;

endmodule
`default_nettype wire

// ----- sv/dssg_store.sv -----
`default_nettype none
module dssg_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [dssg_pkg::LW_W-1:0]     wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [dssg_pkg::LW_W-1:0]     rd_data
);
	import dssg_pkg::*;

	logic [LW_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- sv/dssg_seq.sv -----
`default_nettype none
module dssg_seq #(
	parameter int MAX_LINE_WIDTH = dssg_pkg::MAX_LINE_WIDTH_DEF,
	parameter int DEPTH          = 32,
	parameter int AW             = 5,
	parameter int NM_W           = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic        [dssg_pkg::LW_W-1:0]     line_width,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [dssg_pkg::COORD_W-1:0]  center_x,
	input  logic signed [dssg_pkg::COORD_W-1:0]  center_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dssg_pkg::SPAN_W-1:0]   span_x,
	output logic signed [dssg_pkg::SPAN_W-1:0]   span_y,
	output logic        [dssg_pkg::LW_W-1:0]     span_width,
	output logic                                 last_span,
	output dssg_pkg::adder_op_t                  add_op,
	output logic signed [dssg_pkg::E_W-1:0]      add_e,
	output logic        [dssg_pkg::XY_W-1:0]     add_x,
	output logic        [dssg_pkg::XY_W-1:0]     add_y,
	input  logic signed [dssg_pkg::E_W-1:0]      add_sum,
	input  logic signed [dssg_pkg::E_W-1:0]      add_ex_step,
	output logic                                 st_wr_en,
	output logic        [AW-1:0]                 st_wr_addr,
	output logic        [dssg_pkg::LW_W-1:0]     st_wr_data,
	output logic        [AW-1:0]                 st_rd_addr,
	input  logic        [dssg_pkg::LW_W-1:0]     st_rd_data
);
	import dssg_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ADD   = 6'b000010,
		S_STEP  = 6'b000100,
		S_EMIT  = 6'b001000,
		S_MRD   = 6'b010000,
		S_MEMIT = 6'b100000
	} state_t;

	state_t                    state_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic        [XY_W-1:0]    x_q;
	logic        [XY_W-1:0]    y_q;
	logic signed [E_W-1:0]     e_q;
	logic signed [E_W-1:0]     ex_q;
	logic        [NM_W-1:0]    nm_q;
	logic        [NM_W-1:0]    j_q;

	logic                      out_valid_q;
	logic signed [SPAN_W-1:0]  span_x_q;
	logic signed [SPAN_W-1:0]  span_y_q;
	logic        [LW_W-1:0]    span_width_q;
	logic                      last_span_q;

	logic                      accept;
	logic                      out_free;
	logic        [LW_W-1:0]    w_eff;
	logic        [XY_W-1:0]    y_init;
	logic signed [E_W-1:0]     y_init_e;
	logic signed [E_W-1:0]     e_init;
	logic                      on_boundary;
	logic        [LW_W-1:0]    row_width;
	logic                      row_store;
	logic                      row_load;
	logic                      mir_load;
	logic        [NM_W-1:0]    mir_off;
	logic signed [SPAN_W-1:0]  cx_ext;
	logic signed [SPAN_W-1:0]  cy_ext;
	logic signed [SPAN_W-1:0]  row_x;
	logic signed [SPAN_W-1:0]  row_y;
	logic signed [SPAN_W-1:0]  mir_x;
	logic signed [SPAN_W-1:0]  mir_y;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (line_width == '0) begin
			w_eff = LW_W'(1);
		end else if (line_width > LW_W'(MAX_LINE_WIDTH)) begin
			w_eff = LW_W'(MAX_LINE_WIDTH);
		end else begin
			w_eff = line_width;
		end
	end

	assign y_init   = XY_W'(w_eff[LW_W-1:1]) + XY_W'(1);
	assign y_init_e = {{(E_W-XY_W){1'b0}}, y_init};
	assign e_init   = w_eff[0] ? -((y_init_e <<< 2) + E_W'(3)) : -(y_init_e <<< 3);

	assign add_op = (state_q == S_ADD) ? OP_ROW : OP_STEP;
	assign add_e  = e_q;
	assign add_x  = x_q;
	assign add_y  = y_q;

	assign on_boundary = (e_q == ex_q);
	assign row_width   = (on_boundary && x_q != '0) ? {x_q, 1'b0} : {x_q, 1'b1};
	assign row_load    = (state_q == S_EMIT) && out_free;
	assign row_store   = (y_q != '0) && ((x_q != '0) || !on_boundary)
		&& (nm_q < NM_W'(DEPTH));
	assign mir_load    = (state_q == S_MEMIT) && out_free;

	assign st_wr_en   = row_load && row_store;
	assign st_wr_addr = nm_q[AW-1:0];
	assign st_wr_data = row_width;

	// stack read: next entry is fetched as soon as the current one leaves
	assign mir_off    = (mir_load ? (nm_q - j_q - NM_W'(1)) : (nm_q - j_q));
	assign st_rd_addr = mir_off[AW-1:0];

	assign cx_ext = {cx_q[COORD_W-1], cx_q};
	assign cy_ext = {cy_q[COORD_W-1], cy_q};
	assign row_x  = cx_ext - $signed({{(SPAN_W-XY_W){1'b0}}, x_q});
	assign row_y  = cy_ext - $signed({{(SPAN_W-XY_W){1'b0}}, y_q});
	assign mir_x  = cx_ext - $signed({{(SPAN_W-LW_W+1){1'b0}}, st_rd_data[LW_W-1:1]});
	assign mir_y  = cy_ext + $signed({{(SPAN_W-NM_W){1'b0}}, j_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			nm_q        <= '0;
			j_q         <= '0;
		end else begin
			if (row_load || mir_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						nm_q    <= '0;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (e_q[E_W-1]) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (row_store) begin
							nm_q <= nm_q + NM_W'(1);
						end
						if (y_q != '0) begin
							state_q <= S_ADD;
						end else if (nm_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= NM_W'(1);
							state_q <= S_MRD;
						end
					end
				end
				S_MRD: begin
					state_q <= S_MEMIT;
				end
				S_MEMIT: begin
					if (out_free) begin
						if (j_q == nm_q) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + NM_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the midpoint loop
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= center_x;
			cy_q <= center_y;
			x_q  <= '0;
			y_q  <= y_init;
			e_q  <= e_init;
			ex_q <= -E_W'(4);
		end else if (state_q == S_ADD) begin
			e_q <= add_sum;
		end else if (state_q == S_STEP) begin
			if (!e_q[E_W-1]) begin
				x_q  <= x_q + XY_W'(1);
				ex_q <= add_ex_step;
				e_q  <= add_sum;
			end else begin
				y_q <= y_q - XY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (row_load) begin
			span_x_q     <= row_x;
			span_y_q     <= row_y;
			span_width_q <= row_width;
			last_span_q  <= (y_q == '0) && (nm_q == '0);
		end else if (mir_load) begin
			span_x_q     <= mir_x;
			span_y_q     <= mir_y;
			span_width_q <= st_rd_data;
			last_span_q  <= (j_q == nm_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign span_x     = span_x_q;
	assign span_y     = span_y_q;
	assign span_width = span_width_q;
	assign last_span  = last_span_q;

endmodule
`default_nettype wire

// ----- sv/disk_scanline_span_generator_top.sv -----
// Filled-disk span generator. Each input beat carries a disk centre; the block returns
// line_width spans (diameter from the APB register at offset 0, 0 read as 1, values
// above MAX_LINE_WIDTH clamped), one per row in increasing y, last_span set on the
// final one. The block takes one disk at a time: in_ready stays low from the accepted
// beat until the final span has been loaded into the output register. The rows from the
// top down to the centre come from a midpoint error term run through one shared adder:
// each of the w/2+1 upper rows passes through S_ADD, S_STEP and S_EMIT, with S_STEP
// repeated for every x step (about w/2 steps in total), and the w/2-1 or so mirrored
// rows below the centre are read back from a small stack memory after a read-start
// state (S_MRD), one per cycle while the output is not stalled.
`default_nettype none
module disk_scanline_span_generator_top #(
	parameter int MAX_LINE_WIDTH = dssg_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic        [dssg_pkg::APB_AW-1:0]   paddr,
	input  logic        [dssg_pkg::APB_DW-1:0]   pwdata,
	output logic        [dssg_pkg::APB_DW-1:0]   prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [dssg_pkg::COORD_W-1:0]  center_x,
	input  logic signed [dssg_pkg::COORD_W-1:0]  center_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dssg_pkg::SPAN_W-1:0]   span_x,
	output logic signed [dssg_pkg::SPAN_W-1:0]   span_y,
	output logic        [dssg_pkg::LW_W-1:0]     span_width,
	output logic                                 last_span
);
	import dssg_pkg::*;

	localparam int STORE_DEPTH = (MAX_LINE_WIDTH / 2 > 0) ? MAX_LINE_WIDTH / 2 : 1;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int NM_W        = $clog2(STORE_DEPTH + 1);

	logic [LW_W-1:0]      line_width_q;
	logic                 reg_sel;

	adder_op_t             add_op;
	logic signed [E_W-1:0] add_e;
	logic [XY_W-1:0]       add_x;
	logic [XY_W-1:0]       add_y;
	logic signed [E_W-1:0] add_sum;
	logic signed [E_W-1:0] add_ex_step;

	logic                  st_wr_en;
	logic [STORE_AW-1:0]   st_wr_addr;
	logic [LW_W-1:0]       st_wr_data;
	logic [STORE_AW-1:0]   st_rd_addr;
	logic [LW_W-1:0]       st_rd_data;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1:2] == REG_LINE_WIDTH);
	assign prdata  = reg_sel ? {{(APB_DW-LW_W){1'b0}}, line_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			line_width_q <= pwdata[LW_W-1:0];
		end
	end

	dssg_adder u_adder (
		.op      (add_op),
		.e       (add_e),
		.x       (add_x),
		.y       (add_y),
		.sum     (add_sum),
		.ex_step (add_ex_step)
	);

	dssg_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	dssg_seq #(
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH),
		.DEPTH          (STORE_DEPTH),
		.AW             (STORE_AW),
		.NM_W           (NM_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_width  (line_width_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.center_x    (center_x),
		.center_y    (center_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.span_x      (span_x),
		.span_y      (span_y),
		.span_width  (span_width),
		.last_span   (last_span),
		.add_op      (add_op),
		.add_e       (add_e),
		.add_x       (add_x),
		.add_y       (add_y),
		.add_sum     (add_sum),
		.add_ex_step (add_ex_step),
		.st_wr_en    (st_wr_en),
		.st_wr_addr  (st_wr_addr),
		.st_wr_data  (st_wr_data),
		.st_rd_addr  (st_rd_addr),
		.st_rd_data  (st_rd_data)
	);

endmodule
`default_nettype wire

// ----- sv/dssg_checker.sv -----
`default_nettype none
module dssg_checker #(
	parameter int MAX_LINE_WIDTH = dssg_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [dssg_pkg::SPAN_W-1:0]   span_x,
	input  logic signed [dssg_pkg::SPAN_W-1:0]   span_y,
	input  logic        [dssg_pkg::LW_W-1:0]     span_width,
	input  logic                                 last_span
);
	import dssg_pkg::*;

	// one disk at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a disk is in progress");

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_width != '0) && (span_width <= LW_W'(MAX_LINE_WIDTH)))
		else $error("span width out of range");

	// rows of one disk climb by exactly one
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_span ##1 out_valid |->
		span_y == $past(span_y) + SPAN_W'(1))
		else $error("span rows not consecutive");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_x) && $stable(span_y)
		&& $stable(span_width) && $stable(last_span))
		else $error("stalled output beat changed");

endmodule

bind disk_scanline_span_generator_top dssg_checker #(
	.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
) u_dssg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.span_x     (span_x),
	.span_y     (span_y),
	.span_width (span_width),
	.last_span  (last_span)
);
`default_nettype wire
